FILE: hdl/ddo_pkg.sv
package ddo_pkg;

    localparam int COUNT_BITS   = 16;
    localparam int GAIN_W       = 32;
    localparam int ACC_W        = 64;
    localparam int ANG_W        = 48;
    localparam int HEADING_W    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int IDX_W        = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 32;
    localparam int MUL_W        = 32;
    localparam int Q_SHIFT      = 30;
    localparam int CFG_IDX_W    = 4;

    // sum and difference of two counts, their magnitude times a gain
    localparam int SUM_W    = COUNT_BITS + 1;
    localparam int DS_MAG_W = COUNT_BITS + GAIN_W;
    localparam int DS_W     = DS_MAG_W + 1;
    localparam int HI_W     = DS_MAG_W - Q_SHIFT;
    localparam int MAG_W    = HI_W + MUL_W + 1;

    localparam logic signed [XY_W-1:0] CORDIC_K    = XY_W'(652032874);
    localparam logic [63:0]            TWO_PI_Q60  = 64'h6487_ED51_10B4_611A;

    localparam logic [CFG_IDX_W-1:0] REG_LIN_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ANG_GAIN = CFG_IDX_W'(1);

    typedef logic [CORDIC_STEPS-1:0][ANG_W-1:0] atan_tbl_t;

    // floor(2^e / d) by restoring long division
    function automatic logic [63:0] pow2_div(input int e, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], (b == e)};
            quo = {quo[62:0], 1'b0};
            if (rem >= d) begin
                rem    = rem - d;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // arctangent of 2^-i as binary angle, 2^48 per turn
    function automatic atan_tbl_t build_atan_tbl();
        atan_tbl_t   tbl;
        logic [63:0] rad;
        logic [63:0] r;
        logic [63:0] q;
        int          e;
        tbl = '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                tbl[i] = ANG_W'(1) << (ANG_W - 3);
            end else begin
                rad = '0;
                for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                    e = 62 - i * (2 * k + 1);
                    if ((k & 1) != 0) begin
                        rad = rad - pow2_div(e, 64'(2 * k + 1));
                    end else begin
                        rad = rad + pow2_div(e, 64'(2 * k + 1));
                    end
                end
                r = rad;
                q = '0;
                for (int n = 0; n < ANG_W - 2; n++) begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= TWO_PI_Q60) begin
                        r    = r - TWO_PI_Q60;
                        q[0] = 1'b1;
                    end
                end
                tbl[i] = q[ANG_W-1:0];
            end
        end
        return tbl;
    endfunction

    localparam atan_tbl_t ATAN_TBL = build_atan_tbl();

endpackage

FILE: hdl/ddo_mul.sv
module ddo_mul (
    input  logic                       aclk,
    input  logic [ddo_pkg::MUL_W-1:0]  a,
    input  logic [ddo_pkg::MUL_W-1:0]  b,
    output logic [2*ddo_pkg::MUL_W-1:0] p
);
    import ddo_pkg::*;

    logic [2*MUL_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: hdl/ddo_cordic.sv
module ddo_cordic (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ddo_pkg::ANG_W-1:0]         angle,
    output logic                              done,
    output logic signed [ddo_pkg::XY_W-1:0]   cos_out,
    output logic signed [ddo_pkg::XY_W-1:0]   sin_out
);
    import ddo_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_MAP
    } state_t;

    state_t                    state_reg;
    logic [IDX_W-1:0]          cnt_reg;
    logic [1:0]                quad_reg;
    logic signed [XY_W-1:0]    x_reg;
    logic signed [XY_W-1:0]    y_reg;
    logic signed [ANG_W-1:0]   z_reg;
    logic signed [XY_W-1:0]    cos_reg;
    logic signed [XY_W-1:0]    sin_reg;
    logic                      done_reg;

    logic signed [XY_W-1:0]    dx;
    logic signed [XY_W-1:0]    dy;
    logic signed [ANG_W-1:0]   rot;

    assign dx  = y_reg >>> cnt_reg;
    assign dy  = x_reg >>> cnt_reg;
    assign rot = $signed(ATAN_TBL[cnt_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == S_MAP);
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        x_reg     <= CORDIC_K;
                        y_reg     <= '0;
                        z_reg     <= $signed({2'b00, angle[ANG_W-3:0]});
                        quad_reg  <= angle[ANG_W-1:ANG_W-2];
                        cnt_reg   <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT: begin
                    // rotate toward zero residual angle
                    if (!z_reg[ANG_W-1]) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - rot;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + rot;
                    end
                    cnt_reg <= cnt_reg + IDX_W'(1);
                    if (cnt_reg == IDX_W'(CORDIC_STEPS - 1)) begin
                        state_reg <= S_MAP;
                    end
                end
                S_MAP: begin
                    unique case (quad_reg)
                        2'd0: begin
                            cos_reg <= x_reg;
                            sin_reg <= y_reg;
                        end
                        2'd1: begin
                            cos_reg <= -y_reg;
                            sin_reg <= x_reg;
                        end
                        2'd2: begin
                            cos_reg <= -x_reg;
                            sin_reg <= -y_reg;
                        end
                        default: begin
                            cos_reg <= y_reg;
                            sin_reg <= -x_reg;
                        end
                    endcase
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

FILE: hdl/diff_drive_odometry_core.sv
// Dead-reckoning odometry for a two-wheel robot. Each input word carries one
// control period's signed left and right encoder counts; the block returns
// one word with the updated x and y position, the 16-bit binary heading and
// the saturating relative distance and turn. Write lin_gain (index 0) and
// ang_gain (index 1) while the block is idle. A result is loaded into the
// output register once its word is through, and the block takes the next
// word in the cycle after that, so no new word goes in while one is in flight;
// a result that is not taken holds the block until the output register frees
// up. The time is set by the 24-iteration cordic rotator with its mapping and
// hand-off, and by six passes through the single shared 32x32 multiplier that
// forms both gains and both position increments.
module diff_drive_odometry_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ddo_pkg::GAIN_W-1:0]           cfg_wdata,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ddo_pkg::COUNT_BITS-1:0] s_left_count,
    input  logic signed [ddo_pkg::COUNT_BITS-1:0] s_right_count,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ddo_pkg::ACC_W-1:0]     m_pos_x,
    output logic signed [ddo_pkg::ACC_W-1:0]     m_pos_y,
    output logic [ddo_pkg::HEADING_W-1:0]        m_heading,
    output logic signed [ddo_pkg::ACC_W-1:0]     m_rel_distance,
    output logic signed [ddo_pkg::ACC_W-1:0]     m_rel_turn
);
    import ddo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DS,
        S_MUL_DTH,
        S_CAP_DTH,
        S_MID,
        S_ROT,
        S_XH,
        S_XL,
        S_YH,
        S_YL,
        S_Y_SUM,
        S_Y_SIGN,
        S_Y_ACC,
        S_OUT
    } state_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    state_t                     state_reg;
    logic [GAIN_W-1:0]          lin_gain_reg;
    logic [GAIN_W-1:0]          ang_gain_reg;

    logic signed [ACC_W-1:0]    x_acc_reg;
    logic signed [ACC_W-1:0]    y_acc_reg;
    logic [ANG_W-1:0]           heading_reg;
    logic signed [ACC_W-1:0]    dist_acc_reg;
    logic signed [ACC_W-1:0]    turn_acc_reg;

    logic [SUM_W-1:0]           sum_mag_reg;
    logic                       sum_neg_reg;
    logic [SUM_W-1:0]           diff_mag_reg;
    logic                       diff_neg_reg;
    logic [DS_MAG_W-1:0]        ds_mag_reg;
    logic signed [DS_W-1:0]     ds_reg;
    logic signed [DS_W-1:0]     dth_reg;
    logic [MUL_W-1:0]           cmag_reg;
    logic [MUL_W-1:0]           smag_reg;
    logic                       xneg_reg;
    logic                       yneg_reg;
    logic [MAG_W-1:0]           t_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic signed [MAG_W:0]      inc_reg;

    logic                       m_valid_reg;
    logic signed [ACC_W-1:0]    m_pos_x_reg;
    logic signed [ACC_W-1:0]    m_pos_y_reg;
    logic [HEADING_W-1:0]       m_heading_reg;
    logic signed [ACC_W-1:0]    m_rel_distance_reg;
    logic signed [ACC_W-1:0]    m_rel_turn_reg;

    logic signed [SUM_W-1:0]    in_sum;
    logic signed [SUM_W-1:0]    in_diff;
    logic [MUL_W-1:0]           mul_a;
    logic [MUL_W-1:0]           mul_b;
    logic [2*MUL_W-1:0]         mul_p;
    logic signed [DS_W-1:0]     prod_val;
    logic [MAG_W-1:0]           prod_sum;
    logic signed [MAG_W:0]      mag_val;
    logic [ANG_W-1:0]           mid_angle;
    logic                       cordic_start;
    logic                       cordic_done;
    logic signed [XY_W-1:0]     cos_val;
    logic signed [XY_W-1:0]     sin_val;
    logic                       out_free;
    logic                       s_accept;

    assign in_sum   = SUM_W'(s_left_count) + SUM_W'(s_right_count);
    assign in_diff  = SUM_W'(s_left_count) - SUM_W'(s_right_count);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_DS: begin
                mul_a = MUL_W'(sum_mag_reg);
                mul_b = lin_gain_reg;
            end
            S_MUL_DTH: begin
                mul_a = MUL_W'(diff_mag_reg);
                mul_b = ang_gain_reg;
            end
            S_XH: begin
                mul_a = MUL_W'(ds_mag_reg[DS_MAG_W-1:Q_SHIFT]);
                mul_b = cmag_reg;
            end
            S_XL: begin
                mul_a = MUL_W'(ds_mag_reg[Q_SHIFT-1:0]);
                mul_b = cmag_reg;
            end
            S_YH: begin
                mul_a = MUL_W'(ds_mag_reg[DS_MAG_W-1:Q_SHIFT]);
                mul_b = smag_reg;
            end
            S_YL: begin
                mul_a = MUL_W'(ds_mag_reg[Q_SHIFT-1:0]);
                mul_b = smag_reg;
            end
            default: ;
        endcase
    end

    ddo_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign prod_val     = $signed({1'b0, mul_p[DS_MAG_W-1:0]});
    assign prod_sum     = t_reg + MAG_W'(mul_p >> Q_SHIFT);
    assign mag_val      = $signed({1'b0, mag_reg});
    assign mid_angle    = heading_reg + ANG_W'(dth_reg >>> 1);
    assign cordic_start = (state_reg == S_MID);

    ddo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (mid_angle),
        .done    (cordic_done),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            lin_gain_reg <= '0;
            ang_gain_reg <= '0;
            x_acc_reg    <= '0;
            y_acc_reg    <= '0;
            heading_reg  <= '0;
            dist_acc_reg <= '0;
            turn_acc_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_LIN_GAIN: lin_gain_reg <= cfg_wdata;
                    REG_ANG_GAIN: ang_gain_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // a reload in the output state takes over the valid flag
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        sum_neg_reg  <= in_sum[SUM_W-1];
                        sum_mag_reg  <= in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);
                        diff_neg_reg <= in_diff[SUM_W-1];
                        diff_mag_reg <= in_diff[SUM_W-1] ? SUM_W'(-in_diff) : SUM_W'(in_diff);
                        state_reg    <= S_MUL_DS;
                    end
                end
                S_MUL_DS: begin
                    state_reg <= S_MUL_DTH;
                end
                S_MUL_DTH: begin
                    // product of the distance gain is out now
                    ds_mag_reg <= mul_p[DS_MAG_W-1:0];
                    ds_reg     <= sum_neg_reg ? -prod_val : prod_val;
                    state_reg  <= S_CAP_DTH;
                end
                S_CAP_DTH: begin
                    dth_reg   <= diff_neg_reg ? -prod_val : prod_val;
                    state_reg <= S_MID;
                end
                S_MID: begin
                    // rotator takes the mid-period heading this cycle
                    heading_reg  <= heading_reg + dth_reg[ANG_W-1:0];
                    dist_acc_reg <= sat_add(dist_acc_reg, ACC_W'(ds_reg));
                    turn_acc_reg <= sat_add(turn_acc_reg, ACC_W'(dth_reg));
                    state_reg    <= S_ROT;
                end
                S_ROT: begin
                    if (cordic_done) begin
                        cmag_reg  <= cos_val[XY_W-1] ? MUL_W'(-cos_val) : MUL_W'(cos_val);
                        smag_reg  <= sin_val[XY_W-1] ? MUL_W'(-sin_val) : MUL_W'(sin_val);
                        xneg_reg  <= ds_reg[DS_W-1] != cos_val[XY_W-1];
                        yneg_reg  <= ds_reg[DS_W-1] != sin_val[XY_W-1];
                        state_reg <= S_XH;
                    end
                end
                S_XH: begin
                    state_reg <= S_XL;
                end
                S_XL: begin
                    t_reg     <= MAG_W'(mul_p);
                    state_reg <= S_YH;
                end
                S_YH: begin
                    mag_reg   <= prod_sum;
                    state_reg <= S_YL;
                end
                S_YL: begin
                    t_reg     <= MAG_W'(mul_p);
                    inc_reg   <= xneg_reg ? -mag_val : mag_val;
                    state_reg <= S_Y_SUM;
                end
                S_Y_SUM: begin
                    mag_reg   <= prod_sum;
                    x_acc_reg <= sat_add(x_acc_reg, ACC_W'(inc_reg));
                    state_reg <= S_Y_SIGN;
                end
                S_Y_SIGN: begin
                    inc_reg   <= yneg_reg ? -mag_val : mag_val;
                    state_reg <= S_Y_ACC;
                end
                S_Y_ACC: begin
                    y_acc_reg <= sat_add(y_acc_reg, ACC_W'(inc_reg));
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg        <= 1'b1;
                        m_pos_x_reg        <= x_acc_reg;
                        m_pos_y_reg        <= y_acc_reg;
                        m_heading_reg      <= heading_reg[ANG_W-1:ANG_W-HEADING_W];
                        m_rel_distance_reg <= dist_acc_reg;
                        m_rel_turn_reg     <= turn_acc_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pos_x        = m_pos_x_reg;
    assign m_pos_y        = m_pos_y_reg;
    assign m_heading      = m_heading_reg;
    assign m_rel_distance = m_rel_distance_reg;
    assign m_rel_turn     = m_rel_turn_reg;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ROT_STEPS     = 24;
    localparam int     TURN_W        = 48;
    localparam longint ROT_START     = 652032874;
    localparam longint unsigned FULL_TURN_Q60 = 64'h6487_ED51_10B4_611A;
    localparam longint SAT_HI        = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SAT_LO        = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    localparam int          CNT_MAX       = 32767;
    localparam int          CNT_MIN       = -32768;
    localparam logic [31:0] GAIN_MAX      = 32'hFFFF_FFFF;
    localparam int          SOAK_WORDS    = 8;
    localparam int          RAND_PHASES   = 8;
    localparam int          PHASE_WORDS   = 144;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          REPORT_LIMIT  = 10;

    typedef struct packed {
        logic signed [ddo_pkg::COUNT_BITS-1:0] left;
        logic signed [ddo_pkg::COUNT_BITS-1:0] right;
    } count_pair_t;

    typedef struct packed {
        logic signed [ddo_pkg::ACC_W-1:0]     pos_x;
        logic signed [ddo_pkg::ACC_W-1:0]     pos_y;
        logic        [ddo_pkg::HEADING_W-1:0] heading;
        logic signed [ddo_pkg::ACC_W-1:0]     rel_distance;
        logic signed [ddo_pkg::ACC_W-1:0]     rel_turn;
    } pose_t;

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  cfg_wr_en;
    logic [ddo_pkg::CFG_IDX_W-1:0]         cfg_index;
    logic [ddo_pkg::GAIN_W-1:0]            cfg_wdata;
    logic                                  s_valid;
    logic                                  s_ready;
    logic signed [ddo_pkg::COUNT_BITS-1:0] s_left_count;
    logic signed [ddo_pkg::COUNT_BITS-1:0] s_right_count;
    logic                                  m_valid;
    logic                                  m_ready;
    logic signed [ddo_pkg::ACC_W-1:0]      m_pos_x;
    logic signed [ddo_pkg::ACC_W-1:0]      m_pos_y;
    logic [ddo_pkg::HEADING_W-1:0]         m_heading;
    logic signed [ddo_pkg::ACC_W-1:0]      m_rel_distance;
    logic signed [ddo_pkg::ACC_W-1:0]      m_rel_turn;

    count_pair_t pending_counts[$];
    pose_t       expected_poses[$];
    count_pair_t word_out;
    pose_t       want_pose;

    // tracker copy of the pose and the gains
    longint unsigned atan_rom[ROT_STEPS];
    longint unsigned lin_gain_set;
    longint unsigned ang_gain_set;
    longint          odo_x;
    longint          odo_y;
    longint          odo_dist;
    longint          odo_turn;
    logic [TURN_W-1:0] odo_heading;

    int          sender_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          accepted_words;
    int          checked_results;
    int          saturated_results;
    int          gain_settings;
    logic [3:0]  quadrants_seen;

    diff_drive_odometry_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_count  (s_left_count),
        .s_right_count (s_right_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_heading     (m_heading),
        .m_rel_distance(m_rel_distance),
        .m_rel_turn    (m_rel_turn)
    );

    function automatic longint unsigned mag64(longint v);
        if (v < 0) begin
            return $unsigned(-(v + 1)) + 64'd1;
        end
        return $unsigned(v);
    endfunction

    function automatic longint signed_from_mag(longint unsigned m, bit neg);
        if (!neg) begin
            return (m > $unsigned(SAT_HI)) ? SAT_HI : $signed(m);
        end
        if (m > 64'h8000_0000_0000_0000) begin
            return SAT_LO;
        end
        return $signed(64'd0 - m);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (a >= 0 && b >= 0 && s < 0) begin
            return SAT_HI;
        end
        if (a < 0 && b < 0 && s >= 0) begin
            return SAT_LO;
        end
        return s;
    endfunction

    // distance times a q30 factor, truncated toward zero
    function automatic longint scale_q30(longint d, longint c);
        longint unsigned md;
        longint unsigned mc;
        longint unsigned p;
        md = mag64(d);
        mc = mag64(c);
        p  = (md >> 30) * mc + (((md & 64'h3FFF_FFFF) * mc) >> 30);
        return signed_from_mag(p, (d < 0) != (c < 0));
    endfunction

    function automatic void unit_vector(input logic [TURN_W-1:0] ang,
                                        output longint c, output longint s);
        logic [1:0] quad;
        longint     z;
        longint     x;
        longint     y;
        longint     dx;
        longint     dy;
        quad = ang[TURN_W-1:TURN_W-2];
        z    = ang[TURN_W-3:0];
        x    = ROT_START;
        y    = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - $signed(atan_rom[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + $signed(atan_rom[i]);
            end
        end
        // odd quadrants rotate by a quarter, the upper half negates
        if (quad[0]) begin
            c = -y;
            s = x;
        end else begin
            c = x;
            s = y;
        end
        if (quad[1]) begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic pose_t advance_pose(logic signed [ddo_pkg::COUNT_BITS-1:0] left,
                                           logic signed [ddo_pkg::COUNT_BITS-1:0] right);
        longint            l;
        longint            r;
        longint            ds;
        longint            dth;
        longint            c;
        longint            s;
        logic [TURN_W-1:0] mid;
        pose_t             p;
        l   = left;
        r   = right;
        ds  = signed_from_mag(mag64(l + r) * lin_gain_set, (l + r) < 0);
        dth = signed_from_mag(mag64(l - r) * ang_gain_set, (l - r) < 0);
        mid = odo_heading + TURN_W'(dth >>> 1);
        quadrants_seen[mid[TURN_W-1:TURN_W-2]] = 1'b1;
        unit_vector(mid, c, s);
        odo_x       = add_sat(odo_x, scale_q30(ds, c));
        odo_y       = add_sat(odo_y, scale_q30(ds, s));
        odo_heading = odo_heading + TURN_W'(dth);
        odo_dist    = add_sat(odo_dist, ds);
        odo_turn    = add_sat(odo_turn, dth);
        if (odo_x == SAT_LO || odo_x == SAT_HI || odo_y == SAT_LO || odo_y == SAT_HI ||
            odo_dist == SAT_LO || odo_dist == SAT_HI ||
            odo_turn == SAT_LO || odo_turn == SAT_HI) begin
            saturated_results++;
        end
        p.pos_x        = odo_x;
        p.pos_y        = odo_y;
        p.heading      = odo_heading[TURN_W-1:TURN_W-ddo_pkg::HEADING_W];
        p.rel_distance = odo_dist;
        p.rel_turn     = odo_turn;
        return p;
    endfunction

    function automatic logic signed [ddo_pkg::COUNT_BITS-1:0] pick_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'(int'($urandom_range(0, 600)) - 300);
            4, 5, 6:    return 16'($urandom);
            7: begin
                case ($urandom_range(0, 4))
                    0:       return 16'(CNT_MAX);
                    1:       return 16'(CNT_MIN);
                    2:       return 16'(0);
                    3:       return 16'(-1);
                    default: return 16'(1);
                endcase
            end
            default:    return 16'(int'($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic count_pair_t pick_pair();
        count_pair_t w;
        w.left = pick_count();
        case ($urandom_range(0, 9))
            0, 1:    w.right = w.left;
            2:       w.right = -w.left;
            default: w.right = pick_count();
        endcase
        return w;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return GAIN_MAX;
            3:       return 32'h8000_0000;
            4, 5:    return $urandom_range(1 << 12, 1 << 26);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_word(int l, int r);
        count_pair_t w;
        w.left  = 16'(l);
        w.right = 16'(r);
        pending_counts.push_back(w);
    endtask

    task automatic write_reg(logic [ddo_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == ddo_pkg::REG_LIN_GAIN) begin
            lin_gain_set = val;
            gain_settings++;
        end else if (idx == ddo_pkg::REG_ANG_GAIN) begin
            ang_gain_set = val;
            gain_settings++;
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_counts.size() != 0 || s_valid || expected_poses.size() != 0);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("mismatch on %s at result %0d: expected %h, got %h",
                         name, checked_results, want, got);
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < ROT_STEPS; i++) begin
            longint unsigned rad;
            longint unsigned r;
            longint unsigned q;
            if (i == 0) begin
                atan_rom[i] = 64'd1 << (TURN_W - 3);
            end else begin
                rad = 0;
                for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                    if (k % 2 != 0) begin
                        rad = rad - (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
                    end else begin
                        rad = rad + (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
                    end
                end
                // radians to binary angle, a quarter turn at 2^46
                r = rad;
                q = 0;
                for (int n = 0; n < TURN_W - 2; n++) begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= FULL_TURN_Q60) begin
                        r = r - FULL_TURN_Q60;
                        q = q | 64'd1;
                    end
                end
                atan_rom[i] = q;
            end
        end
    end

    // word source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_poses.push_back(advance_pose(s_left_count, s_right_count));
                accepted_words++;
            end
            if (!s_valid || s_ready) begin
                if (pending_counts.size() != 0 &&
                    int'($urandom_range(0, 99)) >= sender_idle_pct) begin
                    word_out = pending_counts.pop_front();
                    s_valid       <= 1'b1;
                    s_left_count  <= word_out.left;
                    s_right_count <= word_out.right;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_poses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected result word: x %h y %h heading %h",
                                 m_pos_x, m_pos_y, m_heading);
                    end
                end else begin
                    want_pose = expected_poses.pop_front();
                    check_field("pos_x", want_pose.pos_x, m_pos_x);
                    check_field("pos_y", want_pose.pos_y, m_pos_y);
                    check_field("heading", 64'(want_pose.heading), 64'(m_heading));
                    check_field("rel_distance", want_pose.rel_distance, m_rel_distance);
                    check_field("rel_turn", want_pose.rel_turn, m_rel_turn);
                    checked_results++;
                end
            end
            m_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
        end
    end

    initial begin
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_left_count      = '0;
        s_right_count     = '0;
        m_ready           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        sender_idle_pct   = 0;
        recv_stall_pct    = 0;
        mismatches        = 0;
        accepted_words    = 0;
        checked_results   = 0;
        saturated_results = 0;
        gain_settings     = 0;
        quadrants_seen    = '0;
        lin_gain_set      = 0;
        ang_gain_set      = 0;
        odo_x             = 0;
        odo_y             = 0;
        odo_dist          = 0;
        odo_turn          = 0;
        odo_heading       = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // full reverse at heading zero, then full forward
        write_reg(ddo_pkg::REG_LIN_GAIN, GAIN_MAX);
        for (int i = 0; i < SOAK_WORDS; i++) begin
            push_word(CNT_MIN, CNT_MIN);
        end
        repeat (4) push_word(CNT_MAX, CNT_MAX);
        wait_drained();

        // extremes with both gains at full scale; unused indexes must not land
        write_reg(ddo_pkg::REG_ANG_GAIN, GAIN_MAX);
        for (int idx = ddo_pkg::REG_ANG_GAIN + 1; idx < 2 ** ddo_pkg::CFG_IDX_W; idx++) begin
            write_reg(ddo_pkg::CFG_IDX_W'(idx), $urandom);
        end
        push_word(0, 0);
        push_word(CNT_MAX, CNT_MAX);
        push_word(CNT_MIN, CNT_MIN);
        push_word(CNT_MAX, CNT_MIN);
        push_word(CNT_MIN, CNT_MAX);
        push_word(-1, -1);
        push_word(1, -1);
        push_word(-1, 1);
        push_word(21845, -21846);
        push_word(-21846, 21845);
        push_word(0, CNT_MAX);
        push_word(CNT_MIN, 0);
        push_word(100, 37);
        wait_drained();

        write_reg(ddo_pkg::REG_LIN_GAIN, 32'd0);
        write_reg(ddo_pkg::REG_ANG_GAIN, 32'd0);
        push_word(CNT_MAX, CNT_MIN);
        push_word(5, -5);
        wait_drained();

        write_reg(ddo_pkg::REG_LIN_GAIN, 32'd1);
        write_reg(ddo_pkg::REG_ANG_GAIN, 32'd1);
        push_word(CNT_MAX, CNT_MIN);
        push_word(CNT_MIN, CNT_MAX);
        push_word(3, 2);
        wait_drained();

        // quarter turn per word, mid heading on each octant between quadrants
        write_reg(ddo_pkg::REG_LIN_GAIN, 32'h0001_0000);
        write_reg(ddo_pkg::REG_ANG_GAIN, 32'h8000_0000);
        repeat (4) push_word(16384, -16384);
        push_word(-16384, 16384);
        wait_drained();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            write_reg(ddo_pkg::REG_LIN_GAIN, pick_gain());
            write_reg(ddo_pkg::REG_ANG_GAIN, pick_gain());
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 74;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 74;
                end
                default: begin
                    sender_idle_pct = 34;
                    recv_stall_pct  = 34;
                end
            endcase
            repeat (PHASE_WORDS / 2) pending_counts.push_back(pick_pair());
            // hold the source back until every pose is home
            wait_drained();
            repeat (PHASE_WORDS - PHASE_WORDS / 2) pending_counts.push_back(pick_pair());
            wait_drained();
        end

        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("odometry: %0d words in, %0d poses checked over %0d gain writes",
                 accepted_words, checked_results, gain_settings);
        $display("odometry: %0d poses at a saturated accumulator, %0d of 4 heading quadrants",
                 saturated_results, $countones(quadrants_seen));
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d words queued and %0d poses outstanding",
                 pending_counts.size(), expected_poses.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ddo_pkg.sv
hdl/ddo_mul.sv
hdl/ddo_cordic.sv
hdl/diff_drive_odometry_core.sv
tb/sv/testbench.sv
